// ===== hdl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types, constants and helpers for the stream pattern replace block.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int PAT_BYTES   = 8;
    localparam int W_FILL      = $clog2(MAX_PATTERN + 1);
    localparam int W_ADDR      = 5;
    localparam int W_CFG       = 64;

    localparam logic [1:0] REG_OLD_PATTERN = 2'd0;
    localparam logic [1:0] REG_OLD_LEN     = 2'd1;
    localparam logic [1:0] REG_NEW_PATTERN = 2'd2;
    localparam logic [1:0] REG_NEW_LEN     = 2'd3;

    typedef logic [7:0]        t_byte;
    typedef logic [W_FILL-1:0] t_fill;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_word;

    typedef struct packed {
        logic [63:0] old_pattern;
        logic [3:0]  old_len;
        logic [63:0] new_pattern;
        logic [3:0]  new_len;
    } t_cfg;

    // window length: zero acts as one, saturate at the window depth
    function automatic t_fill eff_len(input logic [3:0] len);
        int v;
        v = int'(len);
        if (v < 1) v = 1;
        if (v > MAX_PATTERN) v = MAX_PATTERN;
        return W_FILL'(v);
    endfunction

    function automatic t_fill rep_len(input logic [3:0] len, input t_fill l);
        int v;
        v = int'(len);
        if (v > int'(l)) v = int'(l);
        return W_FILL'(v);
    endfunction

    function automatic t_byte pat_byte(input logic [63:0] w, input int k);
        t_byte b;
        b = '0;
        if (k < PAT_BYTES) b = t_byte'(w >> (8 * k));
        return b;
    endfunction

endpackage

// ===== hdl/spr_cfg.sv =====
// ----------------------------------------------------------------------------
// spr_cfg
// APB register file: search/replace patterns and lengths.
// ----------------------------------------------------------------------------
module spr_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [spr_pkg::W_ADDR-1:0] paddr,
    input  logic [spr_pkg::W_CFG-1:0]  pwdata,
    output logic [spr_pkg::W_CFG-1:0]  prdata,
    output logic                      pready,
    output spr_pkg::t_cfg             o_cfg
);
    import spr_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:3];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.old_pattern <= '0;
            r_cfg.old_len     <= 4'd1;
            r_cfg.new_pattern <= '0;
            r_cfg.new_len     <= 4'd1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_OLD_PATTERN: r_cfg.old_pattern <= pwdata;
                REG_OLD_LEN:     r_cfg.old_len     <= pwdata[3:0];
                REG_NEW_PATTERN: r_cfg.new_pattern <= pwdata;
                REG_NEW_LEN:     r_cfg.new_len     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OLD_PATTERN: prdata = r_cfg.old_pattern;
            REG_OLD_LEN:     prdata = {60'd0, r_cfg.old_len};
            REG_NEW_PATTERN: prdata = r_cfg.new_pattern;
            REG_NEW_LEN:     prdata = {60'd0, r_cfg.new_len};
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== hdl/spr_engine.sv =====
// ----------------------------------------------------------------------------
// spr_engine
// Input register, sliding window, compare and in-place replace.
// At most one pop and/or one push per cycle; a pop waits for output space.
// ----------------------------------------------------------------------------
module spr_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spr_pkg::t_cfg       i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  spr_pkg::t_in_word   i_in_word,
    input  logic                i_space,
    output logic                o_emit,
    output spr_pkg::t_out_word  o_emit_word
);
    import spr_pkg::*;

    logic     r_in_valid, n_in_valid;
    logic     r_pushed, n_pushed;
    t_in_word r_in;
    t_fill    r_fill, n_fill;
    t_byte    r_win [MAX_PATTERN];
    t_byte    n_win [MAX_PATTERN];

    t_fill    len_l, len_r, pos;
    logic     do_pop, do_push, emit_last, step_done, match, accept;

    assign accept     = i_in_valid & o_in_ready;
    assign o_in_ready = ~r_in_valid | step_done;

    always_comb begin
        len_l     = eff_len(i_cfg.old_len);
        len_r     = rep_len(i_cfg.new_len, len_l);
        do_pop    = 1'b0;
        do_push   = 1'b0;
        emit_last = 1'b0;
        step_done = 1'b0;
        n_pushed  = r_pushed;
        n_fill    = r_fill;

        if (r_in_valid) begin
            if (r_pushed) begin
                // flush after last word
                if (i_space) begin
                    do_pop    = 1'b1;
                    emit_last = (r_fill == W_FILL'(1));
                    step_done = emit_last;
                end
            end else if (r_fill > len_l) begin
                if (i_space) do_pop = 1'b1;
            end else if (r_fill == len_l) begin
                if (i_space) begin
                    do_pop  = 1'b1;
                    do_push = 1'b1;
                end
            end else begin
                do_push = 1'b1;
            end
        end

        if (do_push) begin
            if (r_in.in_last) n_pushed = 1'b1;
            else              step_done = 1'b1;
        end
        if (step_done) n_pushed = 1'b0;

        // shift out oldest
        for (int i = 0; i < MAX_PATTERN; i++) n_win[i] = r_win[i];
        if (do_pop) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) n_win[i] = r_win[i + 1];
        end

        pos = do_pop ? r_fill - W_FILL'(1) : r_fill;
        if (do_pop && !do_push)      n_fill = r_fill - W_FILL'(1);
        else if (do_push && !do_pop) n_fill = r_fill + W_FILL'(1);

        if (do_push) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (W_FILL'(i) == pos) n_win[i] = r_in.in_byte;
            end
        end

        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (W_FILL'(i) < len_l && n_win[i] != pat_byte(i_cfg.old_pattern, i))
                match = 1'b0;
        end
        if (do_push && n_fill == len_l && match) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (W_FILL'(i) < len_r) n_win[i] = pat_byte(i_cfg.new_pattern, i);
            end
        end

        if (accept)         n_in_valid = 1'b1;
        else if (step_done) n_in_valid = 1'b0;
        else                n_in_valid = r_in_valid;
    end

    assign o_emit               = do_pop;
    assign o_emit_word.out_byte = r_win[0];
    assign o_emit_word.out_last = emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pushed   <= 1'b0;
            r_fill     <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_pushed   <= n_pushed;
            r_fill     <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_in <= i_in_word;
        for (int i = 0; i < MAX_PATTERN; i++) r_win[i] <= n_win[i];
    end

endmodule

// ===== hdl/spr_out_buf.sv =====
// ----------------------------------------------------------------------------
// spr_out_buf
// Two-entry output skid buffer; space flag is registered-only.
// ----------------------------------------------------------------------------
module spr_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  spr_pkg::t_out_word  i_push_word,
    output logic                o_space,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spr_pkg::t_out_word  o_out_word
);
    import spr_pkg::*;

    t_out_word  r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign o_space     = (r_cnt != 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_word  = r_mem[r_rptr];
    assign pop         = o_out_valid & i_out_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop)      n_cnt = r_cnt + 2'd1;
        else if (pop && !i_push) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) r_wptr <= ~r_wptr;
            if (pop)    r_rptr <= ~r_rptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_push_word;
    end

endmodule

// ===== hdl/stream_pattern_replace.sv =====
// ----------------------------------------------------------------------------
// stream_pattern_replace
// Byte stream search and replace over a sliding window of old_len bytes.
//
//   channel   dir  handshake            payload
//   in        in   i_in_valid/o_in_ready   i_in_word  (in_byte, in_last)
//   out       out  o_out_valid/i_out_ready o_out_word (out_byte, out_last)
//   cfg       in   APB psel/penable        paddr/pwdata/prdata
//
// Steady state: one word per cycle in and out while the output buffer has
// space, set by the one pop/push window step. A last word flushes the whole
// window; a shortened old_len pops the excess bytes before the next push.
// Synchronous active-low reset empties the window and buffers.
// Input acceptance sees i_out_ready only through the registered space flag.
// ----------------------------------------------------------------------------
module stream_pattern_replace (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  spr_pkg::t_in_word          i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output spr_pkg::t_out_word         o_out_word,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spr_pkg::W_ADDR-1:0] paddr,
    input  logic [spr_pkg::W_CFG-1:0]  pwdata,
    output logic [spr_pkg::W_CFG-1:0]  prdata,
    output logic                       pready
);
    import spr_pkg::*;

    t_cfg      cfg;
    logic      emit, space;
    t_out_word emit_word;

    spr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    spr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_space     (space),
        .o_emit      (emit),
        .o_emit_word (emit_word)
    );

    spr_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (emit),
        .i_push_word (emit_word),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== hdl/spr_checker.sv =====
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks for stream_pattern_replace, attached by bind.
// ----------------------------------------------------------------------------
module spr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input spr_pkg::t_out_word         o_out_word,
    input logic                       pready
);
    import spr_pkg::*;

    // words held inside: input register, window, output buffer
    localparam int BAL_MAX = 1 + MAX_PATTERN + 2;
    localparam int W_BAL   = $clog2(BAL_MAX + 2);

    logic [W_BAL-1:0] r_bal, n_bal;
    logic             in_acc, out_acc;

    assign in_acc  = i_in_valid & o_in_ready;
    assign out_acc = o_out_valid & i_out_ready;

    always_comb begin
        n_bal = r_bal;
        if (in_acc && !out_acc)      n_bal = r_bal + W_BAL'(1);
        else if (out_acc && !in_acc) n_bal = r_bal - W_BAL'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bal <= '0;
        else          r_bal <= n_bal;
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_bal != '0)
        else $error("output word with no input word outstanding");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bal <= W_BAL'(BAL_MAX))
        else $error("more words held than storage allows");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind stream_pattern_replace spr_checker u_spr_checker (.*);

// ===== sim/stream_pattern_replace_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_pattern_replace_tb
// Self-checking bench for the sliding-window search and replace block. A
// queue-fed driver offers stream words with random gaps. A clocked monitor
// predicts the words leaving the window from its own window model and checks
// them in order. Registers are set over APB between phases and read back.
// ----------------------------------------------------------------------------
module stream_pattern_replace_tb;
    import spr_pkg::*;

    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_LIMIT    = 4000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                o_in_ready;
    t_in_word            in_word = '0;
    logic                o_out_valid;
    logic                out_ready = 1'b0;
    t_out_word           o_out_word;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [W_ADDR-1:0]   paddr = '0;
    logic [W_CFG-1:0]    pwdata = '0;
    logic [W_CFG-1:0]    prdata;
    logic                pready;

    // window model and register copies
    t_byte       win_bytes [MAX_PATTERN];
    int          win_fill = 0;
    logic [63:0] cfg_old_pat = '0;
    logic [3:0]  cfg_old_len = 4'd1;
    logic [63:0] cfg_new_pat = '0;
    logic [3:0]  cfg_new_len = 4'd1;

    t_in_word    stream_bytes [$];
    t_out_word   due_bytes [$];
    bit          in_taken = 1'b0;
    int          send_gap = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    int          hold_tag = 0;
    int          mismatches = 0;

    stream_pattern_replace u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic int window_len();
        if (cfg_old_len == 4'd0) return 1;
        if (int'(cfg_old_len) > MAX_PATTERN) return MAX_PATTERN;
        return int'(cfg_old_len);
    endfunction

    function automatic t_byte take_oldest();
        t_byte b;
        b = win_bytes[0];
        for (int i = 1; i < win_fill; i++) win_bytes[i-1] = win_bytes[i];
        if (win_fill > 0) win_fill--;
        return b;
    endfunction

    task automatic window_step(input t_in_word w);
        int        len;
        int        reps;
        bit        hit;
        t_out_word o;
        len = window_len();
        while (win_fill >= len && win_fill > 0) begin
            o.out_byte = take_oldest();
            o.out_last = 1'b0;
            due_bytes.push_back(o);
        end
        if (win_fill < MAX_PATTERN) begin
            win_bytes[win_fill] = w.in_byte;
            win_fill++;
        end
        if (win_fill == len) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++)
                if (win_bytes[i] != cfg_old_pat[8*i +: 8]) hit = 1'b0;
            if (hit) begin
                reps = (int'(cfg_new_len) > len) ? len : int'(cfg_new_len);
                for (int i = 0; i < reps; i++) win_bytes[i] = cfg_new_pat[8*i +: 8];
            end
        end
        if (w.in_last) begin
            while (win_fill > 0) begin
                o.out_last = (win_fill == 1);
                o.out_byte = take_oldest();
                due_bytes.push_back(o);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 30)
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    // monitor: predict on accepted input words, check accepted output words
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                in_taken = 1'b1;
                window_step(in_word);
            end
            if (o_out_valid && out_ready) begin
                if (due_bytes.size() == 0) begin
                    report_mismatch("unexpected word", 64'(o_out_word), '0);
                end else begin
                    want = due_bytes.pop_front();
                    if (o_out_word.out_byte !== want.out_byte)
                        report_mismatch("out_byte", 64'(o_out_word.out_byte),
                                        64'(want.out_byte));
                    if (o_out_word.out_last !== want.out_last)
                        report_mismatch("out_last", 64'(o_out_word.out_last),
                                        64'(want.out_last));
                end
            end
        end
    end

    function automatic int pick_send_gap();
        int r;
        if (send_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    always @(negedge i_clk) begin : driver
        logic     nxt_valid;
        t_in_word nxt_word;
        nxt_valid = in_valid;
        nxt_word  = in_word;
        if (in_taken) begin
            nxt_valid = 1'b0;
            send_gap  = pick_send_gap();
        end
        if (!nxt_valid && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (stream_bytes.size() > 0) begin
                nxt_valid = 1'b1;
                nxt_word  = stream_bytes.pop_front();
            end
        end
        in_valid <= nxt_valid;
        in_word  <= nxt_word;
    end

    // receiver
    always @(negedge i_clk) begin : receiver
        int   stall;
        int   seen_tag;
        int   r;
        logic nxt_ready;
        if (hold_tag != seen_tag) begin
            seen_tag = hold_tag;
            stall    = HOLD_CYCLES;
        end
        if (stall > 0) begin
            stall--;
            nxt_ready = 1'b0;
        end else if (recv_calm) begin
            nxt_ready = 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                nxt_ready = 1'b1;
            end else begin
                nxt_ready = 1'b0;
                stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
            end
        end
        out_ready <= nxt_ready;
    end

    task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [63:0] wdata,
                              output logic [63:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= W_ADDR'({idx, 3'b000});
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        logic [63:0] rd;
        logic [63:0] mask;
        apb_access(idx, 1'b1, val, rd);
        mask = '1;
        case (idx)
            REG_OLD_PATTERN: cfg_old_pat = val;
            REG_OLD_LEN: begin
                cfg_old_len = val[3:0];
                mask = 64'hF;
            end
            REG_NEW_PATTERN: cfg_new_pat = val;
            REG_NEW_LEN: begin
                cfg_new_len = val[3:0];
                mask = 64'hF;
            end
            default: ;
        endcase
        apb_access(idx, 1'b0, '0, rd);
        if ((rd & mask) !== (val & mask))
            report_mismatch($sformatf("readback reg %0d", idx), rd & mask, val & mask);
    endtask

    task automatic set_patterns(input logic [63:0] op, input logic [3:0] ol,
                                input logic [63:0] np, input logic [3:0] nl);
        reg_write(REG_OLD_PATTERN, op);
        reg_write(REG_OLD_LEN, 64'(ol));
        reg_write(REG_NEW_PATTERN, np);
        reg_write(REG_NEW_LEN, 64'(nl));
    endtask

    task automatic push_word(input t_byte b, input bit last);
        t_in_word w;
        w.in_byte = b;
        w.in_last = last;
        stream_bytes.push_back(w);
    endtask

    // random stream content biased toward runs of the search pattern
    task automatic add_stream(input int n, input bit close);
        int k;
        int plen;
        int r;
        plen = window_len();
        k = 0;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                push_word(cfg_old_pat[8*k +: 8], close && (i == n - 1));
                k = (k + 1) % plen;
            end else if (r < 9) begin
                push_word(t_byte'($urandom_range(0, 255)), close && (i == n - 1));
            end else begin
                push_word(cfg_old_pat[7:0], close && (i == n - 1));
                k = 1 % plen;
            end
        end
    endtask

    task automatic drain_wait();
        while (stream_bytes.size() > 0 || in_valid || due_bytes.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_pattern();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom(), $urandom()};
    endfunction

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int          budget;
        int          n;
        int          r;
        bit          close;
        logic [3:0]  ol;
        logic [3:0]  nl;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: one-byte window, zero replaced by zero
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b1);
        drain_wait();

        // repeated two-byte matches, later windows see replaced bytes
        set_patterns(64'h4241, 4'd2, 64'h5958, 4'd2);
        push_word(8'h78, 1'b0);
        push_word(8'h41, 1'b0);
        push_word(8'h42, 1'b0);
        push_word(8'h41, 1'b0);
        push_word(8'h42, 1'b0);
        push_word(8'h42, 1'b1);
        drain_wait();

        // length above the window depth, replacement longer than the pattern
        set_patterns('1, 4'hF, 64'h0123456789ABCDEF, 4'hF);
        repeat (8) push_word(8'hFF, 1'b0);
        drain_wait();

        // length lowered with a full window, zero replacement count
        set_patterns('1, 4'd2, 64'h0123456789ABCDEF, 4'd0);
        push_word(8'h00, 1'b0);
        push_word(8'h5A, 1'b1);
        drain_wait();

        // zero length acts as one
        set_patterns('0, 4'd0, '1, 4'd1);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b1);
        drain_wait();

        for (int ph = 0; ph < 12; ph++) begin
            r = $urandom_range(0, 3);
            if (r == 0) ol = 4'd1;
            else if (r == 1) ol = 4'd8;
            else ol = 4'($urandom_range(0, 15));
            nl = ($urandom_range(0, 4) == 0) ? ol : 4'($urandom_range(0, 15));
            set_patterns(pick_pattern(), ol, pick_pattern(), nl);
            send_calm = (ph == 3 || ph == 7);
            recv_calm = (ph == 7);
            if (ph == 3) hold_tag++;
            budget = 35;
            while (budget > 0) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 10);
                if (n > budget) n = budget;
                close = (ph == 11) || (budget > n) || ($urandom_range(0, 2) != 0);
                add_stream(n, close);
                budget -= n;
                if (ph == 5 && budget > 0) drain_wait();
            end
            drain_wait();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
